// ===== hw/rtl/crsa_pkg.sv =====
// ----------------------------------------------------------------------------
// crsa_pkg
// Shared types, constants and helpers for the classifier rank statistics
// accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crsa_pkg;

  // class and field geometry
  localparam int NUM_CLASSES_DEF = 6;
  localparam int SCORE_FIELDS    = 6;
  localparam int SCORE_W         = 16;
  localparam int LOSS_W          = 16;
  localparam int SQ_W            = 2 * LOSS_W;
  localparam int IDX_W           = 3;
  localparam int CNT_W           = 32;
  localparam int SUM_W           = 48;
  localparam int SUMSQ_W         = 64;
  localparam int CELL_ADDR_W     = $clog2(SCORE_FIELDS * SCORE_FIELDS);

  // stream word widths
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 248;

  // command codes
  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef logic [SCORE_FIELDS-1:0][SCORE_W-1:0] score_vec_t;

  // running statistics
  typedef struct packed {
    logic [CNT_W-1:0]   tests;
    logic [CNT_W-1:0]   hits;
    logic [LOSS_W-1:0]  min_loss;
    logic [LOSS_W-1:0]  max_loss;
    logic [SUM_W-1:0]   sum_loss;
    logic [SUMSQ_W-1:0] sum_sq;
  } stats_t;

  // counter store access for one pipeline advance
  typedef struct packed {
    logic                   rd_en;
    logic [CELL_ADDR_W-1:0] rd_addr;
    logic                   wr_en;
    logic [CELL_ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]       wr_data;
  } store_req_t;

  // number of classes that take part in the compare
  function automatic int active_classes(input int n);
    int a;
    a = (n > SCORE_FIELDS) ? SCORE_FIELDS : n;
    if (a < 1) a = 1;
    return a;
  endfunction

endpackage

// ===== hw/rtl/classifier_rank_stats_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// classifier_rank_stats_accumulator_top
// Records classifier tests (prediction, label rank, loss statistics) and
// reads rank-by-label counter cells.
// ----------------------------------------------------------------------------
// pipeline: an accepted word passes the input and result register stages
// throughput: one word per cycle while m_tready is high; the counter
//   read-modify-write spans the two stages via a bypass on the memory port
// reset: clears statistics and the per-cell valid flags, so the
//   counter memory reads zero without a clearing pass
`timescale 1ns / 1ps

module classifier_rank_stats_accumulator_top
  import crsa_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // score_0..score_5 [95:0], loss [111:96], label [114:112],
  // rank_select [117:115], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command [0]
  input  logic                  s_tuser,
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // classified [2:0], rank [5:3], correct [6], tests_done [38:7],
  // correct_total [70:39], min_loss [86:71], max_loss [102:87],
  // sum_loss [150:103], sum_loss_squared [214:151], cell_count [246:215],
  // zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int Active = active_classes(NUM_CLASSES);

  // input register stage
  logic              s1_valid;
  cmd_t              s1_cmd;
  score_vec_t        s1_scores;
  logic [LOSS_W-1:0] s1_loss;
  logic [SQ_W-1:0]   s1_sq;
  logic [IDX_W-1:0]  s1_label;
  logic [IDX_W-1:0]  s1_row;

  // result register stage
  logic              s2_valid;
  logic [IDX_W-1:0]  s2_classified;
  logic [IDX_W-1:0]  s2_rank;
  logic              s2_correct;
  logic              s2_write;
  logic              s2_read_ok;
  logic [CELL_ADDR_W-1:0] s2_addr;

  logic              advance;
  logic              in_word;
  logic [LOSS_W-1:0] in_loss;
  logic [IDX_W-1:0]  classified;
  logic [IDX_W-1:0]  rank;
  logic              is_record;
  logic              label_ok;
  logic              do_write;
  logic              do_read;
  logic              hit;
  logic [IDX_W-1:0]  cell_row;
  logic [CELL_ADDR_W-1:0] cell_addr;
  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  cell_next;
  logic [CNT_W-1:0]  cell_count;
  store_req_t        store_req;
  stats_t            stats;

  // pipeline handshake
  assign advance  = !s2_valid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign in_word  = s_tvalid && s_tready;
  assign in_loss  = s_tdata[6*SCORE_W +: LOSS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // input capture, loss squared here to keep the sum path short
  always_ff @(posedge clk) begin
    if (in_word) begin
      s1_cmd    <= cmd_t'(s_tuser);
      s1_scores <= s_tdata[SCORE_FIELDS*SCORE_W-1:0];
      s1_loss   <= in_loss;
      s1_sq     <= {{LOSS_W{1'b0}}, in_loss} * {{LOSS_W{1'b0}}, in_loss};
      s1_label  <= s_tdata[112 +: IDX_W];
      s1_row    <= s_tdata[115 +: IDX_W];
    end
  end

  crsa_rank_unit #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_rank (
    .scores    (s1_scores),
    .label     (s1_label),
    .classified(classified),
    .rank      (rank)
  );

  // decode of the word in the input stage
  assign is_record = (s1_cmd == CMD_RECORD);
  assign label_ok  = (32'(s1_label) < 32'(Active));
  assign do_write  = s1_valid && is_record && label_ok;
  assign do_read   = s1_valid && !is_record && label_ok && (32'(s1_row) < 32'(Active));
  assign hit       = (classified == s1_label);
  assign cell_row  = is_record ? rank : s1_row;
  assign cell_addr = CELL_ADDR_W'(32'(cell_row) * Active + 32'(s1_label));

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      s2_write   <= 1'b0;
      s2_read_ok <= 1'b0;
    end else if (advance) begin
      s2_valid   <= s1_valid;
      s2_write   <= do_write;
      s2_read_ok <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_classified <= is_record ? classified : '0;
      s2_rank       <= do_write ? rank : '0;
      s2_correct    <= do_write && hit;
      s2_addr       <= cell_addr;
    end
  end

  // counter store: the leaving word writes, the entering word reads
  assign cell_next = (rd_data == '1) ? rd_data : rd_data + CNT_W'(1);

  always_comb begin
    store_req.rd_en   = advance && (do_write || do_read);
    store_req.rd_addr = cell_addr;
    store_req.wr_en   = advance && s2_valid && s2_write;
    store_req.wr_addr = s2_addr;
    store_req.wr_data = cell_next;
  end

  crsa_count_store #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .req    (store_req),
    .rd_data(rd_data)
  );

  crsa_loss_stats u_stats (
    .clk    (clk),
    .rst    (rst),
    .update (advance && do_write),
    .hit    (hit),
    .loss   (s1_loss),
    .loss_sq(s1_sq),
    .stats  (stats)
  );

  // output word
  assign cell_count = s2_write ? cell_next : (s2_read_ok ? rd_data : '0);
  assign m_tvalid   = s2_valid;
  assign m_tdata    = {1'b0, cell_count, stats.sum_sq, stats.sum_loss,
                       stats.max_loss, stats.min_loss, stats.hits, stats.tests,
                       s2_correct, s2_rank, s2_classified};

  // checks
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !s2_valid |-> s_tready) else $error("input stalled with empty result stage");

  a_tests_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> stats.tests >= $past(stats.tests))
    else $error("test count went down");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    stats.hits <= stats.tests) else $error("correct count above test count");

  a_loss_order: assert property (@(posedge clk) disable iff (rst)
    stats.tests != '0 |-> stats.min_loss <= stats.max_loss)
    else $error("minimum loss above maximum loss");

endmodule

// ===== hw/rtl/crsa_rank_unit.sv =====
// ----------------------------------------------------------------------------
// crsa_rank_unit
// Finds the first maximum score and the rank of the label's score, using
// independent pairwise compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsa_rank_unit
  import crsa_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  score_vec_t       scores,
  input  logic [IDX_W-1:0] label,
  output logic [IDX_W-1:0] classified,
  output logic [IDX_W-1:0] rank
);

  localparam int Active = active_classes(NUM_CLASSES);

  logic signed [SCORE_W-1:0] label_score;
  logic [Active-1:0]         is_max;

  // score of the labeled class
  always_comb begin
    label_score = '0;
    for (int i = 0; i < Active; i++) begin
      if (label == IDX_W'(i)) label_score = $signed(scores[i]);
    end
  end

  // first maximum: strictly above all lower indices, not below higher ones
  always_comb begin
    for (int i = 0; i < Active; i++) begin
      is_max[i] = 1'b1;
      for (int j = 0; j < Active; j++) begin
        if (j < i && !($signed(scores[i]) > $signed(scores[j]))) is_max[i] = 1'b0;
        if (j > i && !($signed(scores[i]) >= $signed(scores[j]))) is_max[i] = 1'b0;
      end
    end
  end

  always_comb begin
    classified = '0;
    for (int i = 0; i < Active; i++) begin
      if (is_max[i]) classified = IDX_W'(i);
    end
  end

  // rank: higher scores plus ties at lower indices
  always_comb begin
    rank = '0;
    for (int i = 0; i < Active; i++) begin
      if ($signed(scores[i]) > label_score ||
          ($signed(scores[i]) == label_score && IDX_W'(i) < label)) begin
        rank = rank + IDX_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/crsa_count_store.sv =====
// ----------------------------------------------------------------------------
// crsa_count_store
// Rank-by-label counter memory with per-cell valid flags, registered read
// data and a bypass for a write to the cell read in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsa_count_store
  import crsa_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  store_req_t       req,
  output logic [CNT_W-1:0] rd_data
);

  localparam int Active = active_classes(NUM_CLASSES);
  localparam int Depth  = Active * Active;
  localparam int AW     = $clog2(Depth);

  logic [CNT_W-1:0] mem [Depth];
  logic [Depth-1:0] cell_valid;
  logic [CNT_W-1:0] mem_q;
  logic             hit_q;
  logic             byp_q;
  logic [CNT_W-1:0] byp_data_q;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    wr_idx;

  assign rd_idx = req.rd_addr[AW-1:0];
  assign wr_idx = req.wr_addr[AW-1:0];

  // memory write
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[wr_idx] <= req.wr_data;
  end

  // valid flags, cleared at reset so unwritten cells read zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
    end else if (req.wr_en) begin
      cell_valid[wr_idx] <= 1'b1;
    end
  end

  // registered read with same-cell bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
      byp_q <= 1'b0;
    end else if (req.rd_en) begin
      hit_q <= cell_valid[rd_idx];
      byp_q <= req.wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q      <= mem[rd_idx];
      byp_data_q <= req.wr_data;
    end
  end

  assign rd_data = byp_q ? byp_data_q : (hit_q ? mem_q : '0);

endmodule

// ===== hw/rtl/crsa_loss_stats.sv =====
// ----------------------------------------------------------------------------
// crsa_loss_stats
// Saturating test and hit counters, loss extremes and saturating sums of
// losses and squared losses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsa_loss_stats
  import crsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  logic              hit,
  input  logic [LOSS_W-1:0] loss,
  input  logic [SQ_W-1:0]   loss_sq,
  output stats_t            stats
);

  stats_t          stats_next;
  logic [SUM_W:0]   sum_wide;
  logic [SUMSQ_W:0] sq_wide;

  // saturating updates
  always_comb begin
    sum_wide = {1'b0, stats.sum_loss} + (SUM_W + 1)'(loss);
    sq_wide  = {1'b0, stats.sum_sq} + (SUMSQ_W + 1)'(loss_sq);

    stats_next = stats;
    if (stats.tests != '1) stats_next.tests = stats.tests + CNT_W'(1);
    if (hit && stats.hits != '1) stats_next.hits = stats.hits + CNT_W'(1);
    if (loss < stats.min_loss) stats_next.min_loss = loss;
    if (loss > stats.max_loss) stats_next.max_loss = loss;
    stats_next.sum_loss = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    stats_next.sum_sq   = sq_wide[SUMSQ_W] ? '1 : sq_wide[SUMSQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats.tests    <= '0;
      stats.hits     <= '0;
      stats.min_loss <= '1;
      stats.max_loss <= '0;
      stats.sum_loss <= '0;
      stats.sum_sq   <= '0;
    end else if (update) begin
      stats <= stats_next;
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the classifier rank statistics accumulator. Test
// and read words stream in under random source gaps and sink stalls; a
// predictor keeps its own rank-label store and running statistics and each
// result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import crsa_pkg::*;

  localparam int PERIOD       = 10;
  localparam int CLASSES      = NUM_CLASSES_DEF;
  localparam int RANDOM_WORDS = 750;
  localparam int PHASES       = 4;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  // input word, score_0 in the lowest bits
  typedef struct packed {
    logic [1:0]        pad;
    logic [IDX_W-1:0]  rank_select;
    logic [IDX_W-1:0]  label;
    logic [LOSS_W-1:0] loss;
    score_vec_t        scores;
  } score_word_t;

  // result word, classified in the lowest bits
  typedef struct packed {
    logic               pad;
    logic [CNT_W-1:0]   cell_count;
    logic [SUMSQ_W-1:0] sum_sq;
    logic [SUM_W-1:0]   sum_loss;
    logic [LOSS_W-1:0]  max_loss;
    logic [LOSS_W-1:0]  min_loss;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   tests;
    logic               correct;
    logic [IDX_W-1:0]   rank;
    logic [IDX_W-1:0]   classified;
  } tally_t;

  typedef struct packed {
    cmd_t        cmd;
    score_word_t word;
  } stim_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor state
  logic [CNT_W-1:0]   cell_tally [CLASSES][CLASSES];
  logic [CNT_W-1:0]   test_tally = '0;
  logic [CNT_W-1:0]   hit_tally = '0;
  logic [LOSS_W-1:0]  loss_low = '1;
  logic [LOSS_W-1:0]  loss_high = '0;
  logic [SUM_W-1:0]   loss_sum = '0;
  logic [SUMSQ_W-1:0] loss_sq_sum = '0;

  stim_t  score_words_pending[$];
  tally_t predicted_tallies[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  classifier_rank_stats_accumulator_top #(
    .NUM_CLASSES(CLASSES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(PERIOD / 2) clk = ~clk;

  initial begin
    for (int r = 0; r < CLASSES; r++) begin
      for (int c = 0; c < CLASSES; c++) cell_tally[r][c] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // classify one word, update the tallies, return the expected result word
  function automatic tally_t tally_test(cmd_t cmd, score_word_t w);
    tally_t t;
    logic signed [SCORE_W-1:0] sc [SCORE_FIELDS];
    logic [SUMSQ_W-1:0] sq;
    int i, best, place, lab;
    t = '0;
    for (i = 0; i < SCORE_FIELDS; i++) sc[i] = w.scores[i];
    if (cmd == CMD_READ) begin
      if (w.rank_select < CLASSES && w.label < CLASSES)
        t.cell_count = cell_tally[w.rank_select][w.label];
    end else begin
      best = 0;
      for (i = 1; i < CLASSES; i++) if (sc[i] > sc[best]) best = i;
      t.classified = IDX_W'(best);
      if (w.label < CLASSES) begin
        lab = w.label;
        place = 0;
        for (i = 0; i < CLASSES; i++) begin
          if (sc[i] > sc[lab] || (sc[i] == sc[lab] && i < lab)) place++;
        end
        if (cell_tally[place][lab] != '1) cell_tally[place][lab]++;
        if (test_tally != '1) test_tally++;
        if (best == lab && hit_tally != '1) hit_tally++;
        if (w.loss < loss_low) loss_low = w.loss;
        if (w.loss > loss_high) loss_high = w.loss;
        if (loss_sum > {SUM_W{1'b1}} - SUM_W'(w.loss)) loss_sum = '1;
        else loss_sum = loss_sum + SUM_W'(w.loss);
        sq = SUMSQ_W'(w.loss) * SUMSQ_W'(w.loss);
        if (loss_sq_sum > {SUMSQ_W{1'b1}} - sq) loss_sq_sum = '1;
        else loss_sq_sum = loss_sq_sum + sq;
        t.rank       = IDX_W'(place);
        t.correct    = (best == lab);
        t.cell_count = cell_tally[place][lab];
      end
    end
    t.tests    = test_tally;
    t.hits     = hit_tally;
    t.min_loss = loss_low;
    t.max_loss = loss_high;
    t.sum_loss = loss_sum;
    t.sum_sq   = loss_sq_sum;
    return t;
  endfunction

  function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    end
  endfunction

  function automatic void check_tally(tally_t want, tally_t got);
    flag_field("classified", want.classified, got.classified);
    flag_field("rank", want.rank, got.rank);
    flag_field("correct", want.correct, got.correct);
    flag_field("tests_done", want.tests, got.tests);
    flag_field("correct_total", want.hits, got.hits);
    flag_field("min_loss", want.min_loss, got.min_loss);
    flag_field("max_loss", want.max_loss, got.max_loss);
    flag_field("sum_loss", want.sum_loss, got.sum_loss);
    flag_field("sum_loss_squared", want.sum_sq, got.sum_sq);
    flag_field("cell_count", want.cell_count, got.cell_count);
  endfunction

  // source side: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        predicted_tallies = {predicted_tallies,
                             tally_test(cmd_t'(s_tuser), score_word_t'(s_tdata))};
      if (!s_tvalid || s_tready) begin
        if (score_words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser  <= score_words_pending[0].cmd;
          s_tdata  <= score_words_pending[0].word;
          score_words_pending.delete(0);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_tallies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) $display("result word with none predicted");
        end else begin
          check_tally(predicted_tallies[0], tally_t'(m_tdata));
          predicted_tallies.delete(0);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** classifier_rank_stats_accumulator_top: FAILED **");
      $finish;
    end
  end

  function automatic score_vec_t scores_of(int a0, int a1, int a2, int a3, int a4, int a5);
    score_vec_t s;
    s[0] = SCORE_W'(a0);
    s[1] = SCORE_W'(a1);
    s[2] = SCORE_W'(a2);
    s[3] = SCORE_W'(a3);
    s[4] = SCORE_W'(a4);
    s[5] = SCORE_W'(a5);
    return s;
  endfunction

  function automatic score_vec_t random_scores();
    score_vec_t s;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < SCORE_FIELDS; i++) begin
      case (mode)
        // extremes and zero, plenty of ties
        0: s[i] = {1'($urandom_range(1)), {(SCORE_W - 1){1'($urandom_range(1))}}};
        // narrow band around zero
        1: s[i] = SCORE_W'($urandom_range(8) - 4);
        default: s[i] = SCORE_W'($urandom);
      endcase
    end
    // occasionally one clear winner
    if (mode == 3) s[$urandom_range(SCORE_FIELDS - 1)] = 16'h7FFF;
    return s;
  endfunction

  function automatic logic [LOSS_W-1:0] random_loss();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return LOSS_W'($urandom_range(255));
      default: return LOSS_W'($urandom);
    endcase
  endfunction

  function automatic void queue_record(score_vec_t s, logic [LOSS_W-1:0] loss,
                                       logic [IDX_W-1:0] label);
    stim_t st;
    st.cmd              = CMD_RECORD;
    st.word.pad         = '0;
    st.word.rank_select = IDX_W'($urandom);
    st.word.label       = label;
    st.word.loss        = loss;
    st.word.scores      = s;
    score_words_pending = {score_words_pending, st};
  endfunction

  function automatic void queue_read(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    stim_t st;
    st.cmd              = CMD_READ;
    st.word.pad         = '0;
    st.word.rank_select = row;
    st.word.label       = col;
    st.word.loss        = random_loss();
    st.word.scores      = random_scores();
    score_words_pending = {score_words_pending, st};
  endfunction

  // stimulus: directed words, then random phases with varied idling
  initial begin
    int ph, k;
    while (rst) @(negedge clk);
    @(negedge clk);

    // statistics straight after reset
    queue_read(0, 0);
    // all tied: lowest index wins, label at the bottom
    queue_record(scores_of(0, 0, 0, 0, 0, 0), 16'h0000, 5);
    queue_record(scores_of(-32768, -32768, -32768, -32768, -32768, -32768), 16'hFFFF, 0);
    queue_record(scores_of(-32768, -32768, -32768, -32768, -32768, 32767), 16'h0001, 5);
    queue_record(scores_of(32767, 32767, 32767, 32767, 32767, 32767), 16'h8000, 3);
    queue_record(scores_of(500, 400, 300, 200, 100, 0), 16'h0100, 2);
    queue_record(scores_of(0, 100, 200, 300, 400, 500), 16'h7FFF, 0);
    // equal scores ahead of the label count toward its rank
    queue_record(scores_of(100, -5, 100, 7, 100, -32768), 16'h00FF, 4);
    // labels past the class count are dropped
    queue_record(scores_of(1, 2, 3, 4, 5, 6), 16'h1234, 6);
    queue_record(scores_of(-1, -2, -3, -4, -5, -6), 16'hFFFE, 7);
    queue_record(random_scores(), random_loss(), 1);
    queue_read(5, 5);
    queue_read(2, 2);
    queue_read(3, 3);
    queue_read(5, 0);
    queue_read(2, 4);
    // reads outside the store
    queue_read(6, 0);
    queue_read(0, 6);
    queue_read(7, 7);
    queue_read(6, 3);

    for (ph = 0; ph < PHASES; ph++) begin
      // drain fully before changing the idling mix
      while (score_words_pending.size() != 0 || s_tvalid || predicted_tallies.size() != 0)
        @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (k = 0; k < RANDOM_WORDS / PHASES; k++) begin
        if ($urandom_range(3) == 0)
          queue_read(IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)));
        else if ($urandom_range(9) == 0)
          queue_record(random_scores(), random_loss(), IDX_W'($urandom_range(7, 6)));
        else
          queue_record(random_scores(), random_loss(), IDX_W'($urandom_range(5)));
      end
    end

    while (score_words_pending.size() != 0 || s_tvalid || predicted_tallies.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (predicted_tallies.size() != 0) begin
      $display("%0d predicted result words never arrived", predicted_tallies.size());
      mismatch_count += predicted_tallies.size();
    end
    if (mismatch_count == 0) begin
      $display("** classifier_rank_stats_accumulator_top: PASSED **");
    end else begin
      $display("** classifier_rank_stats_accumulator_top: FAILED **");
    end
    $finish;
  end

endmodule
